@@ rtl/core/itf_pkg.sv @@
// ----------------------------------------------------------------------------
// itf_pkg: shared types and constants for the integer text formatter
// Conversion codes, length codes and the job record that goes from the
// classifier to the character emitter.
// ----------------------------------------------------------------------------
package itf_pkg;

  localparam int MaxWidth = 62;
  localparam int PrecMax  = 60;
  localparam int MaxChars = 62;

  localparam logic [2:0] KIND_SDEC  = 3'd0;
  localparam logic [2:0] KIND_UDEC  = 3'd1;
  localparam logic [2:0] KIND_OCT   = 3'd2;
  localparam logic [2:0] KIND_HEXL  = 3'd3;
  localparam logic [2:0] KIND_HEXU  = 3'd4;
  localparam logic [2:0] KIND_PTR   = 3'd5;

  localparam logic [3:0] LEN_HH  = 4'd0;
  localparam logic [3:0] LEN_H   = 4'd1;
  localparam logic [3:0] LEN_DEF = 4'd2;
  localparam logic [3:0] LEN_BAD = 4'd8;

  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  // classified job handed to the back end
  typedef struct packed {
    logic [63:0] mag;        // magnitude to print
    logic [1:0]  base;
    logic        upper;
    logic        bad;
    logic        neg;
    logic        want_sign;
    logic        sign_space;
    logic        want_prefix;
    logic        oct_alt;
    logic        zero;
    logic        left;
    logic [5:0]  width;
    logic        prec_set;
    logic [5:0]  prec;
  } itf_job_t;

  function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
    logic [7:0] c;
    if (d < 4'd10) c = 8'h30 + {4'd0, d};
    else if (upper) c = 8'h41 + {4'd0, d} - 8'd10;
    else c = 8'h61 + {4'd0, d} - 8'd10;
    return c;
  endfunction

endpackage

@@ rtl/core/itf_front.sv @@
// ----------------------------------------------------------------------------
// itf_front: input classifier
// Cuts the argument to its length, sign-extends and negates, saturates
// width and precision, and writes one job word into a two-entry queue.
// ----------------------------------------------------------------------------
module itf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [63:0]         raw_value,
  input  logic [2:0]          conv_kind,
  input  logic [3:0]          length_mod,
  input  logic                flag_alt,
  input  logic                flag_zero,
  input  logic                flag_left,
  input  logic                flag_space,
  input  logic                flag_plus,
  input  logic [5:0]          field_width,
  input  logic signed [6:0]   min_digits,
  output logic                job_valid,
  input  logic                job_ready,
  output itf_pkg::itf_job_t   job
);
  import itf_pkg::*;

  itf_job_t  q [2];
  logic      wr_ptr, rd_ptr;
  logic [1:0] fill;
  itf_job_t  cj;
  logic [63:0] n;
  logic        msb;
  logic        is_ptr, is_sgn;
  logic [5:0]  prec_c;

  always_comb begin
    is_ptr = (conv_kind == KIND_PTR);
    is_sgn = (conv_kind == KIND_SDEC);
    unique case (length_mod)
      LEN_HH:  begin n = {56'd0, raw_value[7:0]};  msb = raw_value[7];  end
      LEN_H:   begin n = {48'd0, raw_value[15:0]}; msb = raw_value[15]; end
      LEN_DEF: begin n = {32'd0, raw_value[31:0]}; msb = raw_value[31]; end
      default: begin n = raw_value;                msb = raw_value[63]; end
    endcase
    if (min_digits[6]) prec_c = 6'd0;
    else if (min_digits > 7'sd60) prec_c = 6'(PrecMax);
    else prec_c = min_digits[5:0];
    cj = '0;
    cj.bad = !is_ptr && (length_mod >= LEN_BAD);
    cj.neg = !is_ptr && is_sgn && msb;
    if (is_ptr) cj.mag = raw_value;
    else if (cj.neg) begin
      unique case (length_mod)
        LEN_HH:  cj.mag = 64'd0 - {{56{1'b1}}, n[7:0]};
        LEN_H:   cj.mag = 64'd0 - {{48{1'b1}}, n[15:0]};
        LEN_DEF: cj.mag = 64'd0 - {{32{1'b1}}, n[31:0]};
        default: cj.mag = 64'd0 - n;
      endcase
    end else cj.mag = n;
    if (conv_kind == KIND_OCT) cj.base = BASE_OCT;
    else if (conv_kind == KIND_HEXL || conv_kind == KIND_HEXU || is_ptr) cj.base = BASE_HEX;
    else cj.base = BASE_DEC;
    cj.upper       = (conv_kind == KIND_HEXU);
    cj.want_sign   = cj.neg || (is_sgn && (flag_space || flag_plus));
    cj.sign_space  = flag_space;
    cj.want_prefix = ((conv_kind == KIND_HEXL || conv_kind == KIND_HEXU) && flag_alt) || is_ptr;
    cj.oct_alt     = (conv_kind == KIND_OCT) && flag_alt;
    cj.zero        = flag_zero;
    cj.left        = flag_left;
    cj.width       = (field_width > 6'(MaxWidth)) ? 6'(MaxWidth) : field_width;
    cj.prec_set    = !min_digits[6];
    cj.prec        = prec_c;
  end

  assign in_ready  = (fill != 2'd2);
  assign job_valid = (fill != 2'd0);
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) q[wr_ptr] <= cj;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= !wr_ptr;
      if (job_valid && job_ready) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(in_valid && in_ready) - 2'(job_valid && job_ready);
    end
  end

  a_fill_max: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue overfilled");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    fill == 2'd2 |-> !in_ready) else $error("accept while full");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    fill == 2'd0 |-> !job_valid) else $error("job from empty queue");
endmodule

@@ rtl/core/itf_back.sv @@
// ----------------------------------------------------------------------------
// itf_back: character emitter
// Peels digits into a digit buffer, one per cycle for octal and hex and one
// per divide-by-ten pass for decimal, then walks the fields (pad, sign,
// prefix, zeros, digits, pad), one character a cycle unless output stalls.
// ----------------------------------------------------------------------------
module itf_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  itf_pkg::itf_job_t job,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        char_out,
  output logic              last_char,
  output logic              bad_length
);
  import itf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIG, S_PLAN, S_LPAD, S_SIGN, S_PX0, S_PX1, S_ZPAD, S_PZ, S_DOUT,
    S_RPAD, S_ERR
  } state_t;

  state_t      state;
  itf_job_t    j;
  logic [63:0] n;
  logic [3:0]  digs [22];
  logic [4:0]  nd;     // digit count
  logic [4:0]  di;     // digit read index
  logic [5:0]  cnt;    // run length for current field
  logic [5:0]  pad, pz;
  logic [5:0]  emitted;
  logic [3:0]  dval;
  logic [63:0] n_q;
  logic [6:0]  sz, sz0;
  logic [5:0]  pz0;
  logic        o_busy;
  logic        load;
  logic [1:0]  ph;     // decimal step phase
  logic [63:0] qa;     // partial quotient between decimal phases

  // n / 10 as a series sum split over three phases: two sum steps, then a
  // five-bit remainder fixup (the estimate is low by at most one)
  logic [63:0] q_s1, q_s2, q_c, q10;
  logic [4:0]  r5, dr;
  always_comb begin
    q_s1 = (n >> 1) + (n >> 2);
    q_s1 = q_s1 + (q_s1 >> 4);
    q_s2 = qa + (qa >> 8);
    q_s2 = q_s2 + (q_s2 >> 16);
    q_s2 = q_s2 + (q_s2 >> 32);
    q_c  = qa >> 3;
    r5   = n[4:0] - {q_c[1:0], 3'd0} - {q_c[3:0], 1'b0};
    if (r5 > 5'd9) begin
      q10 = q_c + 64'd1;
      dr  = r5 - 5'd10;
    end else begin
      q10 = q_c;
      dr  = r5;
    end
    unique case (j.base)
      BASE_OCT: begin n_q = n >> 3; dval = {1'b0, n[2:0]}; end
      BASE_HEX: begin n_q = n >> 4; dval = n[3:0]; end
      default:  begin
        n_q  = q10;
        dval = dr[3:0];
      end
    endcase
    sz0 = {2'd0, nd};
    pz0 = 6'd0;
    if (j.prec_set && {1'b0, nd} < j.prec) begin
      pz0 = j.prec - {1'b0, nd};
      sz0 = {1'b0, j.prec};
    end else if (j.oct_alt) begin
      pz0 = 6'd1;
      sz0 = sz0 + 7'd1;
    end
    sz = sz0 + (j.want_prefix ? 7'd2 : 7'd0) + (j.want_sign ? 7'd1 : 7'd0);
  end

  assign job_ready = (state == S_IDLE);

  // next field after a given one, skipping empty ones
  function automatic state_t after(state_t s, itf_job_t jj, logic [5:0] pd,
                                   logic [5:0] pzz);
    state_t r;
    r = S_IDLE;
    if (s == S_PLAN && !jj.left && !jj.zero && pd != 6'd0) r = S_LPAD;
    else if ((s == S_PLAN || s == S_LPAD) && jj.want_sign) r = S_SIGN;
    else if ((s == S_PLAN || s == S_LPAD || s == S_SIGN) && jj.want_prefix) r = S_PX0;
    else if (s == S_PX0) r = S_PX1;
    else if ((s == S_PLAN || s == S_LPAD || s == S_SIGN || s == S_PX1) &&
             !jj.left && jj.zero && pd != 6'd0) r = S_ZPAD;
    else if (s != S_PZ && s != S_DOUT && s != S_RPAD && pzz != 6'd0) r = S_PZ;
    else if (s != S_DOUT && s != S_RPAD) r = S_DOUT;
    else if (s == S_DOUT && jj.left && pd != 6'd0) r = S_RPAD;
    return r;
  endfunction

  state_t nxt;
  logic   emit;
  logic [7:0] ch;
  logic   fin;
  always_comb begin
    emit = 1'b0;
    ch   = 8'h20;
    fin  = 1'b0;
    nxt  = state;
    unique case (state)
      S_LPAD, S_RPAD: begin emit = 1'b1; ch = 8'h20; end
      S_SIGN: begin emit = 1'b1; ch = j.neg ? 8'h2d : (j.sign_space ? 8'h20 : 8'h2b); end
      S_PX0, S_ZPAD, S_PZ: begin emit = 1'b1; ch = 8'h30; end
      S_PX1: begin emit = 1'b1; ch = j.upper ? 8'h58 : 8'h78; end
      S_DOUT: begin emit = 1'b1; ch = digit_char(digs[di], j.upper); end
      default: ;
    endcase
    // field ends when its run count reaches one
    if (emit) begin
      if (state == S_SIGN || state == S_PX0 || state == S_PX1 || cnt == 6'd1)
        nxt = after(state, j, pad, pz);
    end
    fin = emit && (nxt == S_IDLE || emitted == 6'(MaxChars - 1));
  end

  assign o_busy = out_valid && !out_ready;
  assign load   = !o_busy && (emit || state == S_ERR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (job_valid) begin
          j <= job;
          n <= job.mag;
          nd <= 5'd0;
          ph <= 2'd0;
          state <= job.bad ? S_ERR : S_DIG;
        end
        S_DIG: begin
          if (j.base == BASE_DEC && ph == 2'd0) begin
            qa <= q_s1;
            ph <= 2'd1;
          end else if (j.base == BASE_DEC && ph == 2'd1) begin
            qa <= q_s2;
            ph <= 2'd2;
          end else begin
            digs[nd] <= dval;
            nd <= nd + 5'd1;
            n  <= n_q;
            ph <= 2'd0;
            if (n_q == 64'd0) state <= S_PLAN;
          end
        end
        S_PLAN: begin
          pz      <= pz0;
          pad     <= (sz < {1'b0, j.width}) ? j.width - sz[5:0] : 6'd0;
          emitted <= 6'd0;
          di      <= nd - 5'd1;
          state   <= after(S_PLAN, j, (sz < {1'b0, j.width}) ?
                           j.width - sz[5:0] : 6'd0, pz0);
          if (!j.left && !j.zero && sz < {1'b0, j.width}) cnt <= j.width - sz[5:0];
          else if (!j.left && j.zero && sz < {1'b0, j.width}) cnt <= j.width - sz[5:0];
          else if (pz0 != 6'd0) cnt <= pz0;
          else cnt <= {1'b0, nd};
        end
        S_ERR: if (!o_busy) begin
          char_out <= 8'd0; last_char <= 1'b1; bad_length <= 1'b1;
          state <= S_IDLE;
        end
        default: if (!o_busy) begin
          char_out   <= ch;
          last_char  <= fin;
          bad_length <= 1'b0;
          emitted    <= emitted + 6'd1;
          if (state == S_DOUT) di <= di - 5'd1;
          if (fin) state <= S_IDLE;
          else begin
            state <= nxt;
            if (nxt != state) begin
              if (nxt == S_ZPAD || nxt == S_RPAD || nxt == S_LPAD) cnt <= pad;
              else if (nxt == S_PZ) cnt <= pz;
              else if (nxt == S_DOUT) cnt <= {1'b0, nd};
            end else cnt <= cnt - 6'd1;
          end
        end
      endcase
    end
  end

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    job_ready |-> state == S_IDLE) else $error("ready while busy");
  a_nd: assert property (@(posedge clk) disable iff (rst)
    state == S_DIG |-> nd < 5'd22) else $error("digit buffer overrun");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_length |-> last_char) else $error("error word not last");
endmodule

@@ rtl/core/integer_text_formatter_unit.sv @@
// ----------------------------------------------------------------------------
// integer_text_formatter_unit: printf-style integer to ASCII formatter
// Classifier front end, two-entry job queue, per-character back end.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (lsb first)                    | tlast/tuser
// s_axis  | in  | raw_value, conv_kind, length_mod, flags,    | -
//         |     | field_width, min_digits                     |
// m_axis  | out | char_out                                    | last_char /
//         |     |                                             | bad_length
// An input word is queued at its accept edge; the back end then takes it,
// peels the octal or hex digits (up to 22) or the decimal digits over the
// divide-by-ten phases (up to 20), plans the fields, then emits the
// characters in order (at most 62).
// A bad length gives one error word once the job is taken.
// The queue lets the next item be classified while one is emitted.
// rst is synchronous; an output word holds while m_axis_tready is low.
module integer_text_formatter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // raw_value[63:0], conv_kind[66:64], length_mod[70:67], alt 71, zero 72,
  // left 73, space 74, plus 75, field_width[81:76], min_digits[88:82]
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // char_out
  output logic        m_axis_tlast,   // last_char
  output logic        m_axis_tuser    // bad_length
);
  import itf_pkg::*;

  logic     job_valid, job_ready;
  itf_job_t job;

  itf_front u_front (
    .clk, .rst,
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .raw_value   (s_axis_tdata[63:0]),
    .conv_kind   (s_axis_tdata[66:64]),
    .length_mod  (s_axis_tdata[70:67]),
    .flag_alt    (s_axis_tdata[71]),
    .flag_zero   (s_axis_tdata[72]),
    .flag_left   (s_axis_tdata[73]),
    .flag_space  (s_axis_tdata[74]),
    .flag_plus   (s_axis_tdata[75]),
    .field_width (s_axis_tdata[81:76]),
    .min_digits  (s_axis_tdata[88:82]),
    .job_valid, .job_ready, .job
  );

  itf_back u_back (
    .clk, .rst,
    .job_valid, .job_ready, .job,
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .char_out   (m_axis_tdata),
    .last_char  (m_axis_tlast),
    .bad_length (m_axis_tuser)
  );
endmodule
